>>> rtl/aesc_pkg.sv
// Package: character classes, token kinds, result word and defaults for the expression checker.
`timescale 1ns / 1ps

package aesc_pkg;

  localparam int unsigned MaxBracketsDef    = 255;
  localparam int unsigned LineCountWidthDef = 16;
  localparam int unsigned LineNumWidth      = 16;
  localparam int unsigned CharWidth         = 8;

  localparam logic [CharWidth-1:0] CharLf    = 8'd10;
  localparam logic [CharWidth-1:0] CharTab   = 8'd9;
  localparam logic [CharWidth-1:0] CharVt    = 8'd11;
  localparam logic [CharWidth-1:0] CharFf    = 8'd12;
  localparam logic [CharWidth-1:0] CharCr    = 8'd13;
  localparam logic [CharWidth-1:0] CharSpace = 8'd32;
  localparam logic [CharWidth-1:0] CharZero  = 8'd48;
  localparam logic [CharWidth-1:0] CharNine  = 8'd57;
  localparam logic [CharWidth-1:0] CharOpen  = 8'd40;
  localparam logic [CharWidth-1:0] CharClose = 8'd41;
  localparam logic [CharWidth-1:0] CharPlus  = 8'd43;
  localparam logic [CharWidth-1:0] CharMinus = 8'd45;
  localparam logic [CharWidth-1:0] CharStar  = 8'd42;
  localparam logic [CharWidth-1:0] CharSlash = 8'd47;
  localparam logic [CharWidth-1:0] CharPct   = 8'd37;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_DIGIT = 3'd1,
    KIND_OPEN  = 3'd2,
    KIND_CLOSE = 3'd3,
    KIND_OP    = 3'd4,
    KIND_OTHER = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OP,
    CLS_OTHER,
    CLS_SPACE,
    CLS_NEWLINE
  } char_class_e;

  typedef struct packed {
    logic                    done;
    logic                    ok;
    logic [LineNumWidth-1:0] line_num;
  } result_t;

  function automatic char_class_e classify(input logic [CharWidth-1:0] c);
    char_class_e cls;
    if (c == CharLf) begin
      cls = CLS_NEWLINE;
    end else if (c == CharSpace || c == CharTab || c == CharVt || c == CharFf ||
                 c == CharCr) begin
      cls = CLS_SPACE;
    end else if (c >= CharZero && c <= CharNine) begin
      cls = CLS_DIGIT;
    end else if (c == CharOpen) begin
      cls = CLS_OPEN;
    end else if (c == CharClose) begin
      cls = CLS_CLOSE;
    end else if (c == CharPlus || c == CharMinus || c == CharStar || c == CharSlash ||
                 c == CharPct) begin
      cls = CLS_OP;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

endpackage

>>> rtl/arith_expression_syntax_checker.sv
// Top level: arithmetic expression syntax checker with input and result registers.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------------
//   in      | sink      | in_valid_i/in_ready_o   | char_code_i[7:0], end_of_input_i
//   out     | source    | out_valid_o/out_ready_i | line_num_o[15:0], expression_ok_o
//
// One word per cycle is taken while no result is held; a word passes through the input
// register, and its result, if any, is loaded into the result register as the word leaves.
// The line state updates as the word leaves the input register.
// A held result stalls the input register only; the input side refills as it drains.
// Reset clears the line state, the line counter and both valid flags.
`timescale 1ns / 1ps

module arith_expression_syntax_checker #(
  parameter int unsigned MAX_BRACKETS     = aesc_pkg::MaxBracketsDef,
  parameter int unsigned LINE_COUNT_WIDTH = aesc_pkg::LineCountWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [aesc_pkg::CharWidth-1:0]    char_code_i,
  input  logic                              end_of_input_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [aesc_pkg::LineNumWidth-1:0] line_num_o,
  output logic                              expression_ok_o
);

  logic                              in_valid_q;
  logic [aesc_pkg::CharWidth-1:0]    char_q;
  logic                              eoi_q;
  logic                              out_valid_q;
  logic [aesc_pkg::LineNumWidth-1:0] line_num_q;
  logic                              ok_q;
  logic                              advance;
  aesc_pkg::result_t                 res;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  aesc_line_state #(
    .MAX_BRACKETS    (MAX_BRACKETS),
    .LINE_COUNT_WIDTH(LINE_COUNT_WIDTH)
  ) u_line_state (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .char_i(char_q),
    .eoi_i (eoi_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= (out_valid_q && !out_ready_i) || (advance && res.done);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_code_i;
      eoi_q  <= end_of_input_i;
    end
    if (advance && res.done) begin
      line_num_q <= res.line_num;
      ok_q       <= res.ok;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign line_num_o      = line_num_q;
  assign expression_ok_o = ok_q;

  a_newline_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !eoi_q && char_q == aesc_pkg::CharLf |=> out_valid_o)
    else $error("newline word did not load a result");

  a_result_only_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.done |-> advance)
    else $error("line state finished a line without a word");

  a_ready_drop_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a held result");

endmodule

>>> rtl/aesc_line_state.sv
// Per-line syntax state: token order rules, bracket counts and the line counter.
`timescale 1ns / 1ps

module aesc_line_state #(
  parameter int unsigned MAX_BRACKETS     = aesc_pkg::MaxBracketsDef,
  parameter int unsigned LINE_COUNT_WIDTH = aesc_pkg::LineCountWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic [aesc_pkg::CharWidth-1:0]      char_i,
  input  logic                                eoi_i,
  output aesc_pkg::result_t                   res_o
);

  localparam int unsigned CntW = $clog2(MAX_BRACKETS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_BRACKETS);

  aesc_pkg::kind_e             prev_q, prev_d;
  logic                        has_chars_q, has_chars_d;
  logic                        err_q, err_d;
  logic [CntW-1:0]             open_q, open_d;
  logic [CntW-1:0]             close_q, close_d;
  logic                        sad_q, sad_d;
  logic [LINE_COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [31:0]                 cnt_ext;
  logic                        finish;
  logic                        clear;
  logic                        after_operand;
  aesc_pkg::char_class_e       cls;

  assign cls           = aesc_pkg::classify(char_i);
  assign after_operand = (prev_q == aesc_pkg::KIND_DIGIT) || (prev_q == aesc_pkg::KIND_CLOSE);
  assign cnt_ext       = 32'(cnt_d);

  always_comb begin
    prev_d      = prev_q;
    has_chars_d = has_chars_q;
    err_d       = err_q;
    open_d      = open_q;
    close_d     = close_q;
    sad_d       = sad_q;
    cnt_d       = cnt_q;
    finish      = 1'b0;
    clear       = 1'b0;

    if (step_i) begin
      if (eoi_i) begin
        finish = has_chars_q;
        clear  = 1'b1;
      end else if (cls == aesc_pkg::CLS_NEWLINE) begin
        finish = 1'b1;
        clear  = 1'b1;
      end else begin
        has_chars_d = 1'b1;
        if (cls == aesc_pkg::CLS_SPACE) begin
          if (prev_q == aesc_pkg::KIND_DIGIT) begin
            sad_d = 1'b1;
          end
        end else begin
          unique case (cls)
            aesc_pkg::CLS_OPEN: begin
              if (!(prev_q == aesc_pkg::KIND_NONE || prev_q == aesc_pkg::KIND_OPEN ||
                    prev_q == aesc_pkg::KIND_OP)) begin
                err_d = 1'b1;
              end
              if (open_q >= CntMax) begin
                err_d  = 1'b1;
                open_d = CntMax;
              end else begin
                open_d = open_q + 1'b1;
              end
              prev_d = aesc_pkg::KIND_OPEN;
            end
            aesc_pkg::CLS_DIGIT: begin
              if (!(prev_q == aesc_pkg::KIND_DIGIT || prev_q == aesc_pkg::KIND_NONE ||
                    prev_q == aesc_pkg::KIND_OPEN || prev_q == aesc_pkg::KIND_OP) ||
                  sad_q) begin
                err_d = 1'b1;
              end
              prev_d = aesc_pkg::KIND_DIGIT;
            end
            aesc_pkg::CLS_CLOSE: begin
              if (!after_operand) begin
                err_d = 1'b1;
              end
              if (close_q >= CntMax) begin
                err_d   = 1'b1;
                close_d = CntMax;
              end else begin
                close_d = close_q + 1'b1;
              end
              prev_d = aesc_pkg::KIND_CLOSE;
            end
            aesc_pkg::CLS_OP: begin
              if (!after_operand) begin
                err_d = 1'b1;
              end
              prev_d = aesc_pkg::KIND_OP;
            end
            default: begin
              prev_d = aesc_pkg::KIND_OTHER;
            end
          endcase
          sad_d = 1'b0;
        end
      end
    end

    if (finish) begin
      cnt_d = cnt_q + 1'b1;
    end
    if (clear) begin
      prev_d      = aesc_pkg::KIND_NONE;
      has_chars_d = 1'b0;
      err_d       = 1'b0;
      open_d      = '0;
      close_d     = '0;
      sad_d       = 1'b0;
    end
  end

  always_comb begin
    res_o.done     = finish;
    res_o.ok       = !err_q && (open_q == close_q) && (prev_q != aesc_pkg::KIND_OPEN) &&
                     (prev_q != aesc_pkg::KIND_OP);
    res_o.line_num = cnt_ext[aesc_pkg::LineNumWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= aesc_pkg::KIND_NONE;
      has_chars_q <= 1'b0;
      err_q       <= 1'b0;
      open_q      <= '0;
      close_q     <= '0;
      sad_q       <= 1'b0;
      cnt_q       <= '0;
    end else begin
      prev_q      <= prev_d;
      has_chars_q <= has_chars_d;
      err_q       <= err_d;
      open_q      <= open_d;
      close_q     <= close_d;
      sad_q       <= sad_d;
      cnt_q       <= cnt_d;
    end
  end

endmodule

>>> tb/expr_line_checker.sv
// Checker: watches both channels of the expression checker, predicts line verdicts, compares.
`timescale 1ns / 1ps

module expr_line_checker
  import aesc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [CharWidth-1:0]    char_code_i,
  input  logic                    end_of_input_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [LineNumWidth-1:0] line_num_i,
  input  logic                    expression_ok_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic [LineNumWidth-1:0] number;
    logic                    ok;
  } line_verdict_t;

  line_verdict_t                 verdict_q[$];
  kind_e                         last_kind;
  bit                            has_chars;
  bit                            line_bad;
  bit                            gap_after_digit;
  int unsigned                   opens;
  int unsigned                   closes;
  logic [LineCountWidthDef-1:0]  lines_done;
  int                            errors = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  task automatic restart_line();
    last_kind       = KIND_NONE;
    has_chars       = 1'b0;
    line_bad        = 1'b0;
    gap_after_digit = 1'b0;
    opens           = 0;
    closes          = 0;
  endtask

  task automatic count_bracket(inout int unsigned n);
    if (n >= MaxBracketsDef) begin
      line_bad = 1'b1;
      n        = MaxBracketsDef;
    end else begin
      n = n + 1;
    end
  endtask

  task automatic close_line();
    line_verdict_t v;
    lines_done = lines_done + 1'b1;
    v.number   = lines_done[LineNumWidth-1:0];
    v.ok       = !line_bad && opens == closes && last_kind != KIND_OPEN &&
                 last_kind != KIND_OP;
    verdict_q.push_back(v);
    restart_line();
  endtask

  task automatic scan_word(input logic [CharWidth-1:0] c, input logic eoi);
    kind_e k;
    logic  follows_operand;
    if (eoi) begin
      if (has_chars) begin
        close_line();
      end else begin
        restart_line();
      end
    end else if (c == CharLf) begin
      close_line();
    end else begin
      has_chars = 1'b1;
      if (c == CharSpace || c == CharTab || c == CharVt || c == CharFf || c == CharCr) begin
        if (last_kind == KIND_DIGIT) begin
          gap_after_digit = 1'b1;
        end
      end else begin
        if (c >= CharZero && c <= CharNine) begin
          k = KIND_DIGIT;
        end else if (c == CharOpen) begin
          k = KIND_OPEN;
        end else if (c == CharClose) begin
          k = KIND_CLOSE;
        end else if (c == CharPlus || c == CharMinus || c == CharStar || c == CharSlash ||
                     c == CharPct) begin
          k = KIND_OP;
        end else begin
          k = KIND_OTHER;
        end
        follows_operand = (last_kind == KIND_DIGIT || last_kind == KIND_CLOSE);
        case (k)
          KIND_OPEN: begin
            if (!(last_kind inside {KIND_NONE, KIND_OPEN, KIND_OP})) begin
              line_bad = 1'b1;
            end
            count_bracket(opens);
          end
          KIND_DIGIT: begin
            if (!(last_kind inside {KIND_DIGIT, KIND_NONE, KIND_OPEN, KIND_OP}) ||
                gap_after_digit) begin
              line_bad = 1'b1;
            end
          end
          KIND_CLOSE: begin
            if (!follows_operand) begin
              line_bad = 1'b1;
            end
            count_bracket(closes);
          end
          KIND_OP: begin
            if (!follows_operand) begin
              line_bad = 1'b1;
            end
          end
          default: begin
          end
        endcase
        gap_after_digit = 1'b0;
        last_kind       = k;
      end
    end
  endtask

  always @(posedge clk_i) begin
    line_verdict_t want;
    if (!rst_ni) begin
      restart_line();
      lines_done = '0;
      verdict_q.delete();
    end else begin
      if (out_valid_i === 1'b1 && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result: line %0d ok %0b",
                                    line_num_i, expression_ok_i));
        end else begin
          want = verdict_q.pop_front();
          if (line_num_i !== want.number) begin
            report_mismatch($sformatf("line_num got %0d want %0d",
                                      line_num_i, want.number));
          end
          if (expression_ok_i !== want.ok) begin
            report_mismatch($sformatf("expression_ok of line %0d got %b want %b",
                                      want.number, expression_ok_i, want.ok));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        scan_word(char_code_i, end_of_input_i);
      end
    end
    pending_o    <= verdict_q.size();
    fail_count_o <= errors;
  end

endmodule

>>> tb/tb.sv
// Testbench top: clock, reset, character stimulus, result sink, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
  import aesc_pkg::*;

  localparam int RandomWords = 1150;
  localparam int QuietWords  = 150;
  localparam int WatchLimit  = 1000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [CharWidth-1:0]    char_code_i;
  logic                    end_of_input_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [LineNumWidth-1:0] line_num_o;
  logic                    expression_ok_o;

  int                      fail_count;
  int                      pending;
  int                      words_sent = 0;
  int                      in_idle_pct = 0;
  int                      stall_pct = 0;
  int                      stuck_cycles = 0;
  logic [CharWidth-1:0]    line_text[$];

  arith_expression_syntax_checker dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_code_i    (char_code_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .line_num_o     (line_num_o),
    .expression_ok_o(expression_ok_o)
  );

  expr_line_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .char_code_i    (char_code_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .line_num_i     (line_num_o),
    .expression_ok_i(expression_ok_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= WatchLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_word(input logic [CharWidth-1:0] c, input logic eoi);
    int gap;
    if (in_idle_pct != 0 && $urandom_range(1, 100) <= in_idle_pct) begin
      gap = $urandom_range(1, 11);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    char_code_i    <= c;
    end_of_input_i <= eoi;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) begin
      send_word(s[i], 1'b0);
    end
  endtask

  task automatic send_nest(input int depth);
    repeat (depth) send_word(CharOpen, 1'b0);
    send_word(CharZero + 8'd7, 1'b0);
    repeat (depth) send_word(CharClose, 1'b0);
    send_word(CharLf, 1'b0);
  endtask

  function automatic logic [CharWidth-1:0] blank_char();
    case ($urandom_range(0, 4))
      0: return CharTab;
      1: return CharVt;
      2: return CharFf;
      3: return CharCr;
      default: return CharSpace;
    endcase
  endfunction

  function automatic logic [CharWidth-1:0] op_char();
    case ($urandom_range(0, 4))
      0: return CharPlus;
      1: return CharMinus;
      2: return CharStar;
      3: return CharSlash;
      default: return CharPct;
    endcase
  endfunction

  function automatic logic [CharWidth-1:0] digit_char();
    return CharWidth'(CharZero + $urandom_range(0, 9));
  endfunction

  function automatic logic [CharWidth-1:0] token_char();
    case ($urandom_range(0, 5))
      0, 1: return digit_char();
      2: return op_char();
      3: return CharOpen;
      4: return CharClose;
      default: return blank_char();
    endcase
  endfunction

  task automatic add_blanks();
    while ($urandom_range(0, 3) == 0) begin
      line_text.push_back(blank_char());
    end
  endtask

  task automatic end_line();
    foreach (line_text[i]) begin
      send_word(line_text[i], 1'b0);
    end
    if ($urandom_range(0, 14) == 0) begin
      send_word(CharWidth'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_word(CharLf, 1'b0);
    end
  endtask

  task automatic send_expression();
    int  depth;
    bit  more;
    depth = 0;
    more  = 1'b1;
    line_text.delete();
    while (more) begin
      add_blanks();
      while (depth < 8 && $urandom_range(0, 3) == 0) begin
        line_text.push_back(CharOpen);
        depth++;
        add_blanks();
      end
      repeat ($urandom_range(1, 3)) line_text.push_back(digit_char());
      add_blanks();
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        line_text.push_back(CharClose);
        depth--;
        add_blanks();
      end
      if ($urandom_range(0, 2) == 0 || line_text.size() > 40) begin
        more = 1'b0;
      end else begin
        line_text.push_back(op_char());
      end
    end
    repeat (depth) line_text.push_back(CharClose);
    if ($urandom_range(0, 4) == 0) begin
      if ($urandom_range(0, 1) == 0) begin
        line_text[$urandom_range(0, line_text.size() - 1)] =
          CharWidth'($urandom_range(0, 255));
      end else begin
        line_text.insert($urandom_range(0, line_text.size()), token_char());
      end
    end
    end_line();
  endtask

  task automatic send_noise();
    line_text.delete();
    repeat ($urandom_range(0, 12)) begin
      if ($urandom_range(0, 1) == 0) begin
        line_text.push_back(token_char());
      end else begin
        line_text.push_back(CharWidth'($urandom_range(0, 255)));
      end
    end
    end_line();
  endtask

  initial begin
    int random_stop;
    int pick;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    char_code_i    = '0;
    end_of_input_i = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_text("\n");
    send_text("\t(1)\n");
    send_text("+1\n");
    send_text("1 2-3*4/5%6\n");
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(CharWidth'($urandom_range(0, 255)), 1'b1);
    send_word(CharWidth'($urandom_range(0, 255)), 1'b1);

    in_idle_pct = 10;
    stall_pct   = 10;
    send_nest(MaxBracketsDef + 1);

    random_stop = RandomWords;
    while (words_sent < random_stop) begin
      if (words_sent >= random_stop - QuietWords) begin
        in_idle_pct = 0;
        stall_pct   = 0;
      end else begin
        in_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_expression();
      end else if (pick < 92) begin
        send_noise();
      end else begin
        send_word(CharWidth'($urandom_range(0, 255)), 1'b1);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> arith_expression_syntax_checker.f
rtl/aesc_pkg.sv
rtl/aesc_line_state.sv
rtl/arith_expression_syntax_checker.sv
tb/expr_line_checker.sv
tb/tb.sv
